FILE: design/pqfe_pkg.sv
// ----------------------------------------------------------------------------
// pqfe_pkg
// Shared types and codes for the packet queue with flow extraction.
// ----------------------------------------------------------------------------
package pqfe_pkg;

  localparam int KEY_W = 104;

  localparam logic [1:0] FUNC_ENQ = 2'd0;
  localparam logic [1:0] FUNC_DEQ = 2'd1;
  localparam logic [1:0] FUNC_EXT = 2'd2;

  localparam logic [1:0] PORT_DEQ = 2'd0;
  localparam logic [1:0] PORT_EXT = 2'd1;
  localparam logic [1:0] PORT_ENQ = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_NOMAT = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic [1:0]  func;
    logic [63:0] data;
    logic        last;
    logic [63:0] key_low;
    logic [39:0] key_high;
  } req_t;

  typedef struct packed {
    logic [1:0]  port;
    logic [63:0] out_data;
    logic        out_last;
    logic [1:0]  status;
  } rsp_t;

endpackage

FILE: design/pqfe_if.sv
// ----------------------------------------------------------------------------
// pqfe_if
// Valid/ready channel carrying one packed payload.
// ----------------------------------------------------------------------------
interface pqfe_if #(parameter int W = 8);
  logic         valid;
  logic         ready;
  logic [W-1:0] payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: design/pqfe_ram.sv
// ----------------------------------------------------------------------------
// pqfe_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pqfe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

FILE: design/packet_queue_with_flow_extract_unit.sv
// ----------------------------------------------------------------------------
// packet_queue_with_flow_extract_unit
// Slot-based packet buffer with FIFO order list and flow-key extraction.
// ----------------------------------------------------------------------------
// channel | dir | payload | meaning
// req     | in  | req_t   | enqueue word / dequeue / extract request
// rsp     | out | rsp_t   | packet words and status results
//
// Enqueue word: frame RAM write. Extract: key scan over the slots in order,
// plus a list search for each slot whose key matches. Dequeue/extract: list
// removal (order-list shift), then per word a RAM address state (S_READ) and
// an output state (S_OUT) that loads the registered data into rsp.
// Read-out stalls on rsp.ready. Reset clears control and busy
// bits; keys have valid bits (a slot never taken since reset reads key zero).
// ----------------------------------------------------------------------------
module packet_queue_with_flow_extract_unit
  import pqfe_pkg::*;
#(
  parameter int SLOT_COUNT  = 16,
  parameter int FRAME_WORDS = 32
) (
  input logic clk,
  input logic rst,
  pqfe_if.sink   req,
  pqfe_if.source rsp
);
  localparam int SW = $clog2(SLOT_COUNT);
  localparam int PW = $clog2(FRAME_WORDS);
  localparam int CW = $clog2(SLOT_COUNT + 1);
  localparam int QW = $clog2(FRAME_WORDS + 1);
  localparam int AW = SW + PW;

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_FIND, S_SHIFT, S_READ, S_OUT} st_t;
  st_t st;

  req_t r;
  assign r = req_t'(req.payload);

  // Control state
  logic [SLOT_COUNT-1:0] busy, kval;
  logic [SLOT_COUNT-1:0][KEY_W-1:0] keys;
  logic [SW-1:0] olist [SLOT_COUNT];
  logic [CW-1:0] cnt;
  logic [SW-1:0] wslot, cur_slot;
  logic [QW-1:0] wpos;
  logic          in_pkt, dropping;
  logic [SW-1:0] sidx;
  logic [CW-1:0] pidx;
  logic [PW-1:0] rpos;
  logic [1:0]    oport;
  logic [KEY_W-1:0] xkey;
  rsp_t          obuf;
  logic          ovalid;

  // Frame RAM
  logic          fwe;
  logic [AW-1:0] fwa, fra;
  logic [64:0]   frd;
  pqfe_ram #(.WIDTH(65), .DEPTH(SLOT_COUNT * FRAME_WORDS)) u_frames (
    .clk(clk), .we(fwe), .waddr(fwa), .wdata({r.last, r.data}),
    .raddr(fra), .rdata(frd)
  );

  // lowest free slot
  logic [SW-1:0] free_s;
  logic          free_ok;
  always_comb begin
    free_s  = '0;
    free_ok = 1'b0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--)
      if (!busy[i]) begin
        free_s  = SW'(i);
        free_ok = 1'b1;
      end
  end

  logic acc, enq, start_slot;
  logic [SW-1:0] es;
  logic [QW-1:0] wpos_eff;
  assign acc = req.valid && req.ready;
  assign enq = acc && r.func == FUNC_ENQ;
  assign start_slot = enq && !in_pkt && !dropping && free_ok;
  assign es = start_slot ? free_s : wslot;
  assign wpos_eff = start_slot ? '0 : wpos;
  assign fwe = enq && !dropping && (in_pkt || free_ok) && wpos_eff < QW'(FRAME_WORDS);
  assign fwa = {es, wpos_eff[PW-1:0]};
  assign fra = {cur_slot, rpos};

  assign req.ready = st == S_IDLE && (!ovalid || rsp.ready);
  assign rsp.valid = ovalid;
  assign rsp.payload = obuf;

  logic [KEY_W-1:0] skey;
  assign skey = kval[sidx] ? keys[sidx] : '0;

  always_ff @(posedge clk) begin
    logic oset;  // a new request result is loaded this cycle
    oset = 1'b0;
    if (rst) begin
      st <= S_IDLE; busy <= '0; kval <= '0; cnt <= '0; wslot <= '0; wpos <= '0;
      in_pkt <= 1'b0; dropping <= 1'b0; ovalid <= 1'b0;
    end else begin
      unique case (st)
        S_IDLE: if (acc) begin
          if (r.func == FUNC_ENQ) begin
            if (dropping) begin
              if (r.last) dropping <= 1'b0;
            end else if (!in_pkt && !free_ok) begin
              obuf <= '{PORT_ENQ, 64'd0, 1'b1, ST_FULL};
              oset = 1'b1;
              if (!r.last) dropping <= 1'b1;
            end else begin
              if (start_slot) begin
                busy[free_s] <= 1'b1; kval[free_s] <= 1'b1; wslot <= free_s;
                keys[free_s] <= '0;
              end
              if (wpos_eff == QW'(2)) keys[es][7:0] <= r.data[7:0];
              if (wpos_eff == QW'(3)) keys[es][55:8] <= r.data[47:0];
              if (wpos_eff == QW'(4)) keys[es][103:56] <= r.data[63:16];
              wpos <= (wpos_eff < QW'(FRAME_WORDS)) ? wpos_eff + 1'b1 : wpos_eff;
              in_pkt <= !r.last;
              if (r.last && cnt < CW'(SLOT_COUNT)) begin
                olist[cnt[SW-1:0]] <= es; cnt <= cnt + 1'b1;
              end
            end
          end else if (r.func == FUNC_DEQ || r.func == FUNC_EXT) begin
            oport <= (r.func == FUNC_DEQ) ? PORT_DEQ : PORT_EXT;
            if (cnt == '0) begin
              obuf <= '{(r.func == FUNC_DEQ) ? PORT_DEQ : PORT_EXT, 64'd0, 1'b1, ST_EMPTY};
              oset = 1'b1;
            end else if (r.func == FUNC_DEQ) begin
              cur_slot <= olist[0]; pidx <= '0; st <= S_SHIFT;
            end else begin
              xkey <= {r.key_high, r.key_low}; sidx <= '0; st <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (skey == xkey) begin
            cur_slot <= sidx; pidx <= '0; st <= S_FIND;
          end else if (sidx == SW'(SLOT_COUNT - 1)) begin
            obuf <= '{PORT_EXT, 64'd0, 1'b1, ST_NOMAT}; oset = 1'b1; st <= S_IDLE;
          end else sidx <= sidx + 1'b1;
        end
        S_FIND: begin
          if (pidx == cnt) begin
            if (sidx == SW'(SLOT_COUNT - 1)) begin
              obuf <= '{PORT_EXT, 64'd0, 1'b1, ST_NOMAT}; oset = 1'b1; st <= S_IDLE;
            end else begin
              sidx <= sidx + 1'b1; st <= S_SCAN;
            end
          end else if (olist[pidx[SW-1:0]] == cur_slot) st <= S_SHIFT;
          else pidx <= pidx + 1'b1;
        end
        S_SHIFT: begin
          if (pidx + 1'b1 >= cnt) begin
            cnt <= cnt - 1'b1; busy[cur_slot] <= 1'b0; rpos <= '0; st <= S_READ;
          end else begin
            olist[pidx[SW-1:0]] <= olist[SW'(pidx + 1'b1)]; pidx <= pidx + 1'b1;
          end
        end
        S_READ: st <= S_OUT;
        S_OUT: if (!ovalid || rsp.ready) begin
          obuf <= '{oport, frd[63:0],
                    frd[64] || rpos == PW'(FRAME_WORDS - 1), ST_OK};
          oset = 1'b1;
          if (frd[64] || rpos == PW'(FRAME_WORDS - 1)) st <= S_IDLE;
          else begin
            rpos <= rpos + 1'b1; st <= S_READ;
          end
        end
        default: st <= S_IDLE;
      endcase
      // hold until taken, reload when a new result is built
      ovalid <= oset || (ovalid && !rsp.ready);
    end
  end

  a_cnt: assert property (@(posedge clk) disable iff (rst) cnt <= CW'(SLOT_COUNT))
    else $error("list count overflow");
  a_rdy: assert property (@(posedge clk) disable iff (rst) st != S_IDLE |-> !req.ready)
    else $error("ready while busy");
  a_ins: assert property (@(posedge clk) disable iff (rst) !(in_pkt && dropping))
    else $error("packet and drop both active");
endmodule

FILE: sim/tb_packet_queue_with_flow_extract_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_packet_queue_with_flow_extract_unit
// Self-checking bench for the packet queue: an internal slot/list model
// predicts every output word and status, which is compared field by field
// against the DUT. Directed corner cases first, then random traffic with
// bursty requests and a stalling output.
// ----------------------------------------------------------------------------
module tb_packet_queue_with_flow_extract_unit;
  import pqfe_pkg::*;

  localparam int SLOTS  = 16;
  localparam int FWORDS = 32;
  localparam logic [1:0] FUNC_NOP = 2'd3;  // unused code, must be ignored

  logic clk;
  logic rst;

  pqfe_if #(.W($bits(req_t))) req_ch ();
  pqfe_if #(.W($bits(rsp_t))) rsp_ch ();

  packet_queue_with_flow_extract_unit #(
    .SLOT_COUNT (SLOTS),
    .FRAME_WORDS(FWORDS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch.sink),
    .rsp(rsp_ch.source)
  );

  // 12 ns period
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // --------------------------------------------------------------------------
  // Queue model: frame store, busy bits, order list, per-slot flow keys
  // --------------------------------------------------------------------------
  logic [63:0]    frame_data [SLOTS*FWORDS];
  bit             frame_last [SLOTS*FWORDS];
  bit             slot_taken [SLOTS];
  int             fifo_order [$];
  logic [KEY_W-1:0] slot_key [SLOTS];
  int             cur_slot;
  int             cur_pos;
  bit             receiving;
  bit             discarding;

  rsp_t           expected_words [$];
  int             error_count;
  int             items_sent;
  int             burst_left;

  logic [KEY_W-1:0] key_pool [4];

  function automatic void push_word(logic [1:0] p, logic [63:0] d, logic l,
                                    logic [1:0] s);
    rsp_t r;
    r.port     = p;
    r.out_data = d;
    r.out_last = l;
    r.status   = s;
    expected_words.push_back(r);
  endfunction

  // read-out stops at the first stored last bit or at the frame end
  function automatic void read_out(int slot, logic [1:0] p);
    bit fin;
    for (int i = 0; i < FWORDS; i++) begin
      fin = frame_last[slot*FWORDS+i] || (i == FWORDS-1);
      push_word(p, frame_data[slot*FWORDS+i], fin, ST_OK);
      if (fin) break;
    end
  endfunction

  function automatic void predict_queue(req_t r);
    int s;
    logic [KEY_W-1:0] k;
    case (r.func)
      FUNC_ENQ: begin
        if (discarding) begin
          if (r.last) discarding = 0;
        end else begin
          if (!receiving) begin
            s = -1;
            for (int i = SLOTS-1; i >= 0; i--)
              if (!slot_taken[i]) s = i;
            if (s < 0) begin
              // no free slot: one full status, rest of packet discarded
              push_word(PORT_ENQ, 64'd0, 1'b1, ST_FULL);
              if (!r.last) discarding = 1;
              return;
            end
            slot_taken[s] = 1;
            cur_slot = s;
            cur_pos = 0;
            slot_key[s] = '0;
            receiving = 1;
          end
          // key bytes come from words 2, 3 and 4
          if (cur_pos == 2) slot_key[cur_slot][7:0] = r.data[7:0];
          else if (cur_pos == 3) slot_key[cur_slot][55:8] = r.data[47:0];
          else if (cur_pos == 4) slot_key[cur_slot][103:56] = r.data[63:16];
          if (cur_pos < FWORDS) begin
            frame_data[cur_slot*FWORDS+cur_pos] = r.data;
            frame_last[cur_slot*FWORDS+cur_pos] = r.last;
            cur_pos++;
          end
          if (r.last) begin
            receiving = 0;
            fifo_order.push_back(cur_slot);
          end
        end
      end
      FUNC_DEQ: begin
        if (fifo_order.size() == 0) begin
          push_word(PORT_DEQ, 64'd0, 1'b1, ST_EMPTY);
        end else begin
          s = fifo_order.pop_front();
          slot_taken[s] = 0;
          read_out(s, PORT_DEQ);
        end
      end
      FUNC_EXT: begin
        if (fifo_order.size() == 0) begin
          push_word(PORT_EXT, 64'd0, 1'b1, ST_EMPTY);
          return;
        end
        k = {r.key_high, r.key_low};
        // lowest listed slot holding the key wins
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_key[i] != k) continue;
          for (int p = 0; p < fifo_order.size(); p++) begin
            if (fifo_order[p] == i) begin
              fifo_order.delete(p);
              slot_taken[i] = 0;
              read_out(i, PORT_EXT);
              return;
            end
          end
        end
        push_word(PORT_EXT, 64'd0, 1'b1, ST_NOMAT);
      end
      default: ;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Request driver: bursts of random length, random gaps in between
  // --------------------------------------------------------------------------
  task automatic send_request(req_t r);
    if (burst_left == 0) begin
      req_ch.valid = 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
      // now and then a long burst with no gaps at all
      burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 10);
    end
    burst_left--;
    req_ch.valid   = 1'b1;
    req_ch.payload = r;
    do @(posedge clk); while (!req_ch.ready);
    predict_queue(r);
    items_sent++;
    @(negedge clk);
    req_ch.valid = 1'b0;
  endtask

  task automatic send_word(logic [63:0] d, logic l);
    req_t r;
    r = '0;
    r.func = FUNC_ENQ;
    r.data = d;
    r.last = l;
    r.key_low = {$urandom, $urandom};
    r.key_high = 40'({$urandom, $urandom});
    send_request(r);
  endtask

  task automatic send_cmd(logic [1:0] f, logic [KEY_W-1:0] k);
    req_t r;
    r.func = f;
    r.data = {$urandom, $urandom};
    r.last = 1'($urandom_range(0, 1));
    r.key_low = k[63:0];
    r.key_high = k[103:64];
    send_request(r);
  endtask

  // a packet of len words whose flow key (if long enough) is k
  task automatic send_packet(int len, logic [KEY_W-1:0] k, bit mixed);
    logic [63:0] w;
    for (int i = 0; i < len; i++) begin
      w = {$urandom, $urandom};
      if (i == 2) w[7:0] = k[7:0];
      if (i == 3) w[47:0] = k[55:8];
      if (i == 4) w[63:16] = k[103:56];
      send_word(w, i == len-1);
      // dequeue/extract between words of an unfinished packet
      if (mixed && i != len-1 && $urandom_range(0, 7) == 0)
        send_cmd($urandom_range(0, 1) ? FUNC_DEQ : FUNC_EXT,
                 key_pool[$urandom_range(0, 3)]);
    end
  endtask

  task automatic wait_drained();
    while (expected_words.size() != 0) @(negedge clk);
    // extract scan and list removal may still be busy
    repeat (80) @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Output side: random stalls, with quiet stretches of steady ready
  // --------------------------------------------------------------------------
  int stall_left;
  int cyc;
  always @(negedge clk) begin
    cyc <= cyc + 1;
    if (stall_left > 0) begin
      rsp_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (cyc[9:8] != 2'd0 && $urandom_range(0, 3) == 0) begin
      rsp_ch.ready <= 1'b0;
      stall_left <= $urandom_range(0, 7);
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  // Checker: every accepted word against the oldest prediction
  always @(posedge clk) begin
    rsp_t got, want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got = rsp_ch.payload;
      if (expected_words.size() == 0) begin
        $error("unexpected output word port=%0d data=%h", got.port, got.out_data);
        error_count++;
      end else begin
        want = expected_words.pop_front();
        if (got.port !== want.port) begin
          $error("port: expected %0d, got %0d", want.port, got.port);
          error_count++;
        end
        if (got.out_data !== want.out_data) begin
          $error("out_data: expected %h, got %h", want.out_data, got.out_data);
          error_count++;
        end
        if (got.out_last !== want.out_last) begin
          $error("out_last: expected %0d, got %0d", want.out_last, got.out_last);
          error_count++;
        end
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          error_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // empty queue, key extremes, no match, ignored code, all-ones data word
  task automatic test_corner_cases();
    logic [KEY_W-1:0] ones;
    ones = '1;
    send_cmd(FUNC_DEQ, '0);
    send_cmd(FUNC_EXT, ones);
    send_packet(5, ones, 0);
    send_packet(1, '0, 0);           // short packet keeps a zero key
    send_cmd(FUNC_NOP, '0);
    send_cmd(FUNC_EXT, {KEY_W{1'b0}} | 104'h5a);  // nothing matches
    send_cmd(FUNC_EXT, ones);
    send_cmd(FUNC_EXT, '0);
    send_cmd(FUNC_DEQ, '0);
    send_word(64'hffff_ffff_ffff_ffff, 1'b0);
    send_word(64'd0, 1'b1);
    send_cmd(FUNC_DEQ, '0);
  endtask

  // packet longer than a frame: extra words dropped, read-out cut at frame end
  task automatic test_oversize();
    send_packet(FWORDS + 2, key_pool[1], 0);
    send_packet(FWORDS, key_pool[2], 0);
    send_cmd(FUNC_EXT, key_pool[2]);
    send_cmd(FUNC_DEQ, '0);
  endtask

  // fill every slot, then a dropped multi-word packet and a full status
  task automatic test_full_queue();
    for (int i = 0; i < SLOTS; i++) send_packet(1, '0, 0);
    send_packet(3, '0, 0);
    send_packet(1, '0, 0);
    wait_drained();                  // hold off until all results are back
    for (int i = 0; i < SLOTS; i++) send_cmd(FUNC_DEQ, '0);
  endtask

  // random traffic: fill-heavy and drain-heavy phases, shared key pool
  task automatic test_random_traffic();
    int enq_weight;
    int len;
    while (items_sent < 350) begin
      if ($urandom_range(0, 19) == 0) enq_weight = $urandom_range(3, 9);
      case ($urandom_range(0, 9) < enq_weight)
        1'b1: begin
          len = ($urandom_range(0, 15) == 0) ? $urandom_range(20, FWORDS + 2)
                                              : $urandom_range(1, 7);
          send_packet(len, key_pool[$urandom_range(0, 3)], 1);
        end
        default: begin
          case ($urandom_range(0, 9))
            0:       send_cmd(FUNC_NOP, '0);
            1:       send_cmd(FUNC_EXT,
                              KEY_W'({$urandom, $urandom, $urandom, $urandom}));
            2, 3, 4: send_cmd(FUNC_DEQ, '0);
            default: send_cmd(FUNC_EXT, key_pool[$urandom_range(0, 3)]);
          endcase
        end
      endcase
      if (items_sent > 200 && items_sent < 210) wait_drained();
    end
  endtask

  initial begin
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.payload = '0;
    rsp_ch.ready = 1'b0;
    stall_left = 0;
    cyc = 0;
    error_count = 0;
    items_sent = 0;
    burst_left = 0;
    receiving = 0;
    discarding = 0;
    cur_slot = 0;
    cur_pos = 0;
    for (int i = 0; i < SLOTS; i++) begin
      slot_taken[i] = 0;
      slot_key[i] = '0;
    end
    key_pool[0] = '0;
    for (int i = 1; i < 4; i++)
      key_pool[i] = KEY_W'({$urandom, $urandom, $urandom, $urandom});
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_corner_cases();
    test_oversize();
    test_full_queue();
    test_random_traffic();

    wait_drained();
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // hard stop if the DUT hangs
  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: files.f
design/pqfe_pkg.sv
design/pqfe_if.sv
design/pqfe_ram.sv
design/packet_queue_with_flow_extract_unit.sv
sim/tb_packet_queue_with_flow_extract_unit.sv
